### src/scope_trigger_capture_top_defines.svh
// Assertion macros shared by the scope trigger capture RTL.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef SCOPE_TRIGGER_CAPTURE_TOP_DEFINES_SVH
`define SCOPE_TRIGGER_CAPTURE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/stc_pkg.sv
// Shared types, constants and the extent decay function for scope trigger capture.
// No dependencies.
`default_nettype none

package stc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CURSOR_W = 24;
  localparam int STEP_W   = 9;
  localparam int START_W  = 12;
  localparam int CFG_W    = 12;
  localparam int FRAC_W   = 8;

  // Configuration register indexes
  localparam logic REG_CURSOR_STEP  = 1'b0;
  localparam logic REG_SEARCH_START = 1'b1;

  localparam logic [STEP_W-1:0]  CURSOR_STEP_RST  = 9'd256;
  localparam logic [START_W-1:0] SEARCH_START_RST = 12'd192;

  // 0.9999 in Q0.24
  localparam logic [23:0] DECAY_Q24 = 24'd16775538;

  localparam logic signed [SAMPLE_W-1:0] EXTENT_TOP = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] EXTENT_BOT = -16'sd32767;
  localparam logic [CURSOR_W-1:0]        CURSOR_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [STEP_W-1:0]  cursor_step;
    logic [START_W-1:0] search_start;
  } cfg_t;

  typedef struct packed {
    logic triggered;
    logic write_valid;
  } flags_t;

  // Scale magnitude by 0.9999, truncating toward zero
  function automatic logic signed [SAMPLE_W-1:0] decay(input logic signed [SAMPLE_W-1:0] x);
    logic [16:0] mag;
    logic [40:0] prod;
    logic [16:0] dmag;
    mag  = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
    prod = 41'(mag) * 41'(DECAY_Q24);
    dmag = prod[40:24];
    decay = x[15] ? 16'(17'd0 - dmag) : dmag[15:0];
  endfunction

endpackage

`default_nettype wire

### src/stc_core.sv
// Trigger state, cursor and capture span logic for scope trigger capture.
// Depends on stc_pkg and scope_trigger_capture_top_defines.svh.
`default_nettype none
`include "scope_trigger_capture_top_defines.svh"

module stc_core #(
  parameter int CAPTURE_DEPTH = 128,
  parameter int IDX_W         = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stc_pkg::cfg_t                 cfg,
  input  wire logic                          item_valid,
  input  wire logic signed [15:0]            sample,
  output stc_pkg::flags_t                    flags,
  output logic [IDX_W-1:0]                   write_first,
  output logic [IDX_W-1:0]                   write_last,
  output logic signed [15:0]                 write_value
);
  import stc_pkg::*;

  localparam int IDXF_W = CURSOR_W - FRAC_W;
  localparam logic [CURSOR_W-1:0] WIN_LIMIT  = CURSOR_W'((CAPTURE_DEPTH + 1) * 256);
  localparam logic [IDXF_W-1:0]   DEPTH_IDX  = IDXF_W'(CAPTURE_DEPTH);
  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(CAPTURE_DEPTH - 1);

  // State registers
  logic [CURSOR_W-1:0]        cursor_pos, cursor_pos_next;
  logic [CURSOR_W-1:0]        prev_cursor_pos, prev_cursor_pos_next;
  logic signed [SAMPLE_W-1:0] run_min, run_min_next;
  logic signed [SAMPLE_W-1:0] run_max, run_max_next;
  logic                       min_reached, min_reached_next;
  logic                       max_reached, max_reached_next;
  logic signed [SAMPLE_W-1:0] last_sample;

  logic                armed, fire, min_hit, max_hit, in_window, span_ok;
  logic [CURSOR_W-1:0] cur_eff;
  logic [CURSOR_W:0]   cur_sum;
  logic [IDXF_W-1:0]   idx_a, idx_b;

  // Trigger search and extent tracking
  always_comb begin
    armed    = cursor_pos > {{(CURSOR_W-START_W-FRAC_W){1'b0}}, cfg.search_start, 8'd0};
    min_hit  = min_reached;
    max_hit  = max_reached;
    run_min_next     = run_min;
    run_max_next     = run_max;
    min_reached_next = min_reached;
    max_reached_next = max_reached;
    fire = 1'b0;
    if (armed) begin
      if (!min_reached) begin
        min_hit      = sample <= run_min;
        run_min_next = decay(run_min);
      end
      if (!max_reached) begin
        max_hit      = sample >= run_max;
        run_max_next = decay(run_max);
      end
      min_reached_next = min_hit;
      max_reached_next = max_hit;
      fire = min_hit && max_hit && last_sample[15] && !sample[15];
      if (fire) begin
        run_min_next     = EXTENT_TOP;
        run_max_next     = EXTENT_BOT;
        min_reached_next = 1'b0;
        max_reached_next = 1'b0;
      end
    end else begin
      if (sample < run_min) run_min_next = sample;
      if (sample > run_max) run_max_next = sample;
    end
  end

  // Capture span and cursor advance
  always_comb begin
    cur_eff   = fire ? '0 : cursor_pos;
    in_window = cur_eff <= WIN_LIMIT;
    idx_a     = prev_cursor_pos[CURSOR_W-1:FRAC_W];
    idx_b     = cur_eff[CURSOR_W-1:FRAC_W];
    span_ok   = in_window && (idx_a <= idx_b) && (idx_a < DEPTH_IDX);
    flags.write_valid = span_ok;
    flags.triggered   = fire;
    write_first = span_ok ? idx_a[IDX_W-1:0] : '0;
    write_last  = !span_ok ? '0 : (idx_b < DEPTH_IDX ? idx_b[IDX_W-1:0] : LAST_IDX);
    write_value = span_ok ? sample : '0;
    prev_cursor_pos_next = cur_eff;
    cur_sum = {1'b0, cur_eff} + (CURSOR_W+1)'(cfg.cursor_step);
    cursor_pos_next = cur_sum[CURSOR_W] ? CURSOR_MAX : cur_sum[CURSOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_pos      <= '0;
      prev_cursor_pos <= '0;
      run_min         <= EXTENT_TOP;
      run_max         <= EXTENT_BOT;
      min_reached     <= 1'b0;
      max_reached     <= 1'b0;
      last_sample     <= '0;
    end else if (item_valid) begin
      cursor_pos      <= cursor_pos_next;
      prev_cursor_pos <= prev_cursor_pos_next;
      run_min         <= run_min_next;
      run_max         <= run_max_next;
      min_reached     <= min_reached_next;
      max_reached     <= max_reached_next;
      last_sample     <= sample;
    end
  end

  // Trigger restarts the cursor one step in
  `STC_ASSERT_NEXT(a_fire_restart, item_valid && fire, cursor_pos == CURSOR_W'($past(cfg.cursor_step)), "cursor not restarted on trigger")
  // Trigger clears both reached flags
  `STC_ASSERT_NEXT(a_fire_clear, item_valid && fire, !min_reached && !max_reached, "reached flags not cleared on trigger")
  // Tracking phase never changes the reached flags
  `STC_ASSERT_NEXT(a_track_flags, item_valid && !armed, $stable(min_reached) && $stable(max_reached), "reached flags changed while tracking")

endmodule

`default_nettype wire

### src/scope_trigger_capture_top.sv
// Top level of scope trigger capture: stream ports, config registers, pipeline registers.
// Depends on stc_pkg, stc_core and scope_trigger_capture_top_defines.svh.
//
// Usage:
//   s_* carries one signed 16-bit sample per item. m_* returns exactly one result
//   item per sample: tuser flags (write_valid, triggered) and, in tdata, the span
//   of capture indices to fill with the sample value (zero when nothing is written).
//   cfg_wen/cfg_addr/cfg_wdata write cursor_step (index 0) and search_start
//   (index 1); write them only while no item is in flight.
//   Pipeline: two register stages, input register and result register.
//   Throughput: one item per cycle while m_tready is high; the state update
//   between the stages is combinational (extent compare plus one 17x24
//   constant multiply per extent for the decay).
//   Stall: while m_tready is low the result is held; one more sample is taken
//   into the input register, then s_tready drops until the result is taken.
//   Reset: clears both stages, the cursor and the trigger state, and returns
//   cursor_step to 256 and search_start to 192.
`default_nettype none
`include "scope_trigger_capture_top_defines.svh"

module scope_trigger_capture_top #(
  parameter int CAPTURE_DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config write port
  input  wire logic                                   cfg_wen,
  input  wire logic                                   cfg_addr,
  input  wire logic [stc_pkg::CFG_W-1:0]              cfg_wdata,
  // input stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [15:0]                            s_tdata,  // [15:0] sample
  // output stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // low to high: write_first, write_last, write_value, zero fill
  output logic [(((2*$clog2(CAPTURE_DEPTH)+16)+7)/8)*8-1:0] m_tdata,
  output logic [1:0]                                  m_tuser   // [0] write_valid, [1] triggered
);
  import stc_pkg::*;

  localparam int IDX_W  = $clog2(CAPTURE_DEPTH);
  localparam int USED_W = 2 * IDX_W + SAMPLE_W;
  localparam int DATA_W = ((USED_W + 7) / 8) * 8;

  cfg_t cfg;

  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       advance;
  logic                       item_valid;

  flags_t                     flags;
  logic [IDX_W-1:0]           write_first, write_last;
  logic signed [SAMPLE_W-1:0] write_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cursor_step  <= CURSOR_STEP_RST;
      cfg.search_start <= SEARCH_START_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_CURSOR_STEP:  cfg.cursor_step  <= cfg_wdata[STEP_W-1:0];
        REG_SEARCH_START: cfg.search_start <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: result register frees, input register moves forward
  assign advance    = !m_tvalid || m_tready;
  assign s_tready   = !in_valid || advance;
  assign item_valid = in_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata;
    end
  end

  stc_core #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .IDX_W         (IDX_W)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .sample      (in_sample),
    .flags       (flags),
    .write_first (write_first),
    .write_last  (write_last),
    .write_value (write_value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      m_tdata <= DATA_W'({write_value, write_last, write_first});
      m_tuser <= {flags.triggered, flags.write_valid};
    end
  end

  // A written span never runs backward
  `STC_ASSERT_NOW(a_span_order, m_tvalid && m_tuser[0],
    m_tdata[IDX_W-1:0] <= m_tdata[2*IDX_W-1:IDX_W], "span first after last")
  // No write means an all-zero payload
  `STC_ASSERT_NOW(a_zero_payload, m_tvalid && !m_tuser[0], m_tdata == '0,
    "payload not zero without write")
  // An empty result register always takes a new item
  `STC_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready,
    "input stalled with result register empty")

endmodule

`default_nettype wire
